// ----- design/crc_frame_builder_unit_macros.svh -----
// Assertion macros used by the frame builder top level
`ifndef CRC_FRAME_BUILDER_UNIT_MACROS_SVH
`define CRC_FRAME_BUILDER_UNIT_MACROS_SVH

// same-cycle implication
`define CRCFB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed");

// next-cycle implication
`define CRCFB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed");

`endif

// ----- design/crcfb_pkg.sv -----
// Shared constants, types and codes of the CRC frame builder
package crcfb_pkg;

	localparam int MAX_MESSAGE   = 32;
	localparam int CRC_WIDTH     = 8;
	localparam int SYM_W         = 8;
	localparam int BIT_CNT_W     = $clog2(SYM_W);
	localparam int ADDR_W        = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
	localparam int CNT_W         = $clog2(MAX_MESSAGE + 1);
	localparam int POS_W         = $clog2(MAX_MESSAGE + 4);
	localparam int HDR_LEN_W     = 7;
	localparam int HEADER_OFFSET = 4;
	localparam int CFG_IDX_W     = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 1'd1;

	localparam logic [SYM_W-1:0] GENERATOR_RESET = 8'd7;
	localparam logic [SYM_W-1:0] FLAG_RESET      = 8'd126;

	localparam logic [POS_W-1:0] POS_OPEN_FLAG = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA      = POS_W'(2);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CRC  = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic load;
		logic clear;
	} crc_ctrl_t;

	typedef struct packed {
		logic busy;
		logic last_bit;
	} crc_status_t;

endpackage

// ----- design/crcfb_msg_store.sv -----
// Message byte store: one write port, one registered read port
module crcfb_msg_store (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [crcfb_pkg::ADDR_W-1:0]      wr_addr,
	input  logic [crcfb_pkg::SYM_W-1:0]       wr_data,
	input  logic [crcfb_pkg::ADDR_W-1:0]      rd_addr,
	output logic [crcfb_pkg::SYM_W-1:0]       rd_data
);

	logic [crcfb_pkg::SYM_W-1:0] mem_q [crcfb_pkg::MAX_MESSAGE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- design/crcfb_crc_serial.sv -----
// Bit-serial CRC engine, one message bit per cycle, MSB first
module crcfb_crc_serial (
	input  logic                               clk,
	input  logic                               arst_n,
	input  crcfb_pkg::crc_ctrl_t               ctrl,
	input  logic [crcfb_pkg::SYM_W-1:0]        data_in,
	input  logic [crcfb_pkg::CRC_WIDTH-1:0]    generator,
	output logic [crcfb_pkg::CRC_WIDTH-1:0]    crc,
	output crcfb_pkg::crc_status_t             status
);

	logic [crcfb_pkg::CRC_WIDTH-1:0] crc_q;
	logic [crcfb_pkg::CRC_WIDTH-1:0] crc_next;
	logic [crcfb_pkg::SYM_W-1:0]     shift_q;
	logic [crcfb_pkg::BIT_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            feedback;

	always_comb begin
		feedback = crc_q[crcfb_pkg::CRC_WIDTH-1] ^ shift_q[crcfb_pkg::SYM_W-1];
		crc_next = crcfb_pkg::CRC_WIDTH'(crc_q << 1) ^ (feedback ? generator : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (ctrl.clear) begin
				crc_q <= '0;
			end else if (busy_q) begin
				crc_q <= crc_next;
			end
			if (ctrl.load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + crcfb_pkg::BIT_CNT_W'(1);
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			shift_q <= data_in;
		end else if (busy_q) begin
			shift_q <= shift_q << 1;
		end
	end

	assign crc             = crc_q;
	assign status.busy     = busy_q;
	assign status.last_bit = busy_q && (cnt_q == '1);

endmodule

// ----- design/crc_frame_builder_unit.sv -----
// Frame builder top level: byte intake, CRC sequencing and frame output
// Intake: each stored word runs through the CRC one bit per cycle; the next word can be taken during
// its last bit if it did not end the message; a word that finds the store full is dropped.
// Frame output, after the last word's CRC or a dropped last word: flag, header, data words, CRC and
// closing flag; each word is loaded after a priming step for the registered store read, unless stalled.
// Reset (arst_n low, async): count, CRC, overflow mark, output valid cleared; generator 7, flag 126.
`include "crc_frame_builder_unit_macros.svh"

module crc_frame_builder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [crcfb_pkg::SYM_W-1:0]          message_byte,
	input  logic                                 last_byte,
	input  logic                                 odd_frame,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [crcfb_pkg::SYM_W-1:0]          frame_symbol,
	output logic                                 end_of_frame,
	output logic                                 overflowed,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [crcfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crcfb_pkg::SYM_W-1:0]          cfg_data
);

	crcfb_pkg::state_t               state_q;
	logic [crcfb_pkg::SYM_W-1:0]     generator_q;
	logic [crcfb_pkg::SYM_W-1:0]     flag_q;
	logic [crcfb_pkg::CNT_W-1:0]     count_q;
	logic                            overflow_q;
	logic                            last_q;
	logic                            odd_q;
	logic [crcfb_pkg::POS_W-1:0]     pos_q;
	logic                            prime_q;
	logic                            out_valid_q;
	logic [crcfb_pkg::SYM_W-1:0]     symbol_q;
	logic                            eof_q;
	logic                            ovf_out_q;

	crcfb_pkg::crc_ctrl_t            crc_ctrl;
	crcfb_pkg::crc_status_t          crc_st;
	logic [crcfb_pkg::CRC_WIDTH-1:0] crc_value;
	logic [crcfb_pkg::SYM_W-1:0]     rd_data;
	logic [crcfb_pkg::ADDR_W-1:0]    rd_addr;

	logic                            can_accept;
	logic                            accept;
	logic                            store_byte;
	logic                            load_out;
	logic                            closing;
	logic [crcfb_pkg::POS_W-1:0]     data_end;
	logic [crcfb_pkg::SYM_W-1:0]     header;
	logic [crcfb_pkg::SYM_W-1:0]     next_symbol;

	always_comb begin
		can_accept = (state_q == crcfb_pkg::S_IDLE)
			|| ((state_q == crcfb_pkg::S_CRC) && crc_st.last_bit && !last_q);
		accept     = in_valid && can_accept;
		store_byte = accept && (count_q < crcfb_pkg::CNT_W'(crcfb_pkg::MAX_MESSAGE));
		load_out   = (state_q == crcfb_pkg::S_EMIT) && prime_q
			&& (!out_valid_q || !out_stall);
		data_end   = crcfb_pkg::POS_W'(count_q) + crcfb_pkg::POS_DATA;
		rd_addr    = crcfb_pkg::ADDR_W'(pos_q - crcfb_pkg::POS_DATA);
		header     = {odd_q, crcfb_pkg::HDR_LEN_W'(crcfb_pkg::HDR_LEN_W'(count_q)
			+ crcfb_pkg::HDR_LEN_W'(crcfb_pkg::HEADER_OFFSET))};
		closing    = 1'b0;
		if (pos_q == crcfb_pkg::POS_OPEN_FLAG) begin
			next_symbol = flag_q;
		end else if (pos_q == crcfb_pkg::POS_HEADER) begin
			next_symbol = header;
		end else if (pos_q < data_end) begin
			next_symbol = rd_data;
		end else if (pos_q == data_end) begin
			next_symbol = crcfb_pkg::SYM_W'(crc_value);
		end else begin
			next_symbol = flag_q;
			closing     = 1'b1;
		end
		crc_ctrl.load  = store_byte;
		crc_ctrl.clear = load_out && closing;
	end

	crcfb_crc_serial u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (crc_ctrl),
		.data_in   (message_byte),
		.generator (crcfb_pkg::CRC_WIDTH'(generator_q)),
		.crc       (crc_value),
		.status    (crc_st)
	);

	crcfb_msg_store u_store (
		.clk     (clk),
		.wr_en   (store_byte),
		.wr_addr (crcfb_pkg::ADDR_W'(count_q)),
		.wr_data (message_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			generator_q <= crcfb_pkg::GENERATOR_RESET;
			flag_q      <= crcfb_pkg::FLAG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				crcfb_pkg::REG_GENERATOR: generator_q <= cfg_data;
				crcfb_pkg::REG_FLAG:      flag_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= crcfb_pkg::S_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			last_q     <= 1'b0;
			odd_q      <= 1'b0;
			pos_q      <= '0;
			prime_q    <= 1'b0;
		end else begin
			case (state_q)
				crcfb_pkg::S_IDLE, crcfb_pkg::S_CRC: begin
					if (accept) begin
						odd_q <= odd_frame;
						if (store_byte) begin
							count_q <= count_q + crcfb_pkg::CNT_W'(1);
							last_q  <= last_byte;
							state_q <= crcfb_pkg::S_CRC;
						end else begin
							overflow_q <= 1'b1;
							last_q     <= 1'b0;
							state_q    <= last_byte ? crcfb_pkg::S_EMIT : crcfb_pkg::S_IDLE;
						end
					end else if ((state_q == crcfb_pkg::S_CRC) && crc_st.last_bit) begin
						last_q  <= 1'b0;
						state_q <= last_q ? crcfb_pkg::S_EMIT : crcfb_pkg::S_IDLE;
					end
					pos_q   <= '0;
					prime_q <= 1'b0;
				end
				crcfb_pkg::S_EMIT: begin
					if (load_out) begin
						pos_q   <= pos_q + crcfb_pkg::POS_W'(1);
						prime_q <= 1'b0;
						if (closing) begin
							count_q    <= '0;
							overflow_q <= 1'b0;
							state_q    <= crcfb_pkg::S_IDLE;
						end
					end else begin
						prime_q <= 1'b1;
					end
				end
				default: state_q <= crcfb_pkg::S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			symbol_q  <= next_symbol;
			eof_q     <= closing;
			ovf_out_q <= overflow_q;
		end
	end

	assign in_stall     = !can_accept;
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign frame_symbol = symbol_q;
	assign end_of_frame = eof_q;
	assign overflowed   = ovf_out_q;

	`CRCFB_ASSERT_NOW(a_crc_busy_in_crc, state_q == crcfb_pkg::S_CRC, crc_st.busy)
	`CRCFB_ASSERT_NEXT(a_close_to_idle, load_out && closing, state_q == crcfb_pkg::S_IDLE && count_q == '0)
	`CRCFB_ASSERT_NEXT(a_full_sets_overflow, accept && !store_byte, overflow_q)
	`CRCFB_ASSERT_NOW(a_no_intake_in_emit, state_q == crcfb_pkg::S_EMIT, in_stall && !crc_st.busy)

endmodule
